// ----- sv/rsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared types and constants of the reference-counted slot allocator.
// ----------------------------------------------------------------------------
package rsa_pkg;

    localparam int SLOTS_DEF       = 256;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int REQ_W    = 2;
    localparam int IDX_W    = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 16;
    localparam int USED_W   = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLAIM   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_REF     = 2'd2,
        REQ_UNUSED  = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_INVALID = 3'd2,
        ST_DEAD    = 3'd3,
        ST_SAT     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_INIT = 3'b001,
        S_IDLE = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    typedef struct packed {
        logic init_wr;
        logic rd;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic init_last;
        logic out_busy;
    } stat_t;

endpackage

// ----- sv/rsa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_ctrl
// Controller of the slot allocator: memory clearing after reset, item
// acceptance and the execute step.
// ----------------------------------------------------------------------------
module rsa_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rsa_pkg::stat_t stat,
    output rsa_pkg::cmd_t  cmd
);
    import rsa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            S_INIT: begin
                cmd.init_wr = 1'b1;
                if (stat.init_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.rd     = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!stat.out_busy) begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/rsa_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_datapath
// Free stack and count memories, stack pointer, use counter, request
// evaluation and the result register.
// ----------------------------------------------------------------------------
module rsa_datapath #(
    parameter int SLOTS       = rsa_pkg::SLOTS_DEF,
    parameter int COUNT_WIDTH = rsa_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rsa_pkg::cmd_t                  cmd,
    output rsa_pkg::stat_t                 stat,
    input  logic [rsa_pkg::REQ_W-1:0]      s_req_type,
    input  logic [rsa_pkg::IDX_W-1:0]      s_slot_index,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rsa_pkg::STATUS_W-1:0]   m_status,
    output logic [rsa_pkg::IDX_W-1:0]      m_granted_index,
    output logic [rsa_pkg::COUNT_W-1:0]    m_count_after,
    output logic                           m_slot_freed,
    output logic [rsa_pkg::USED_W-1:0]     m_slots_in_use
);
    import rsa_pkg::*;

    localparam int IW = (SLOTS > 2) ? $clog2(SLOTS) : 1;
    localparam int CW = COUNT_WIDTH;

    logic [IW-1:0] slot_stack [SLOTS];
    logic [CW-1:0] ref_counts [SLOTS];

    logic [IW-1:0]    init_reg;
    logic [IW-1:0]    free_top_reg;
    logic [IW-1:0]    free_top_next;
    logic [IW-1:0]    used_reg;
    logic [IW-1:0]    used_next;
    logic [REQ_W-1:0] req_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IW-1:0]    stack_rd_reg;
    logic [CW-1:0]    cnt_rd_reg;

    logic             m_valid_reg;
    status_t          status_reg;
    status_t          status_next;
    logic [IW-1:0]    granted_reg;
    logic [IW-1:0]    granted_next;
    logic [CW-1:0]    cnt_out_reg;
    logic [CW-1:0]    cnt_out_next;
    logic             freed_reg;
    logic             freed_next;

    logic [31:0]   s_idx_wide;
    logic [31:0]   idx_wide;
    logic [IW-1:0] s_addr;
    logic [IW-1:0] idx_addr;
    logic          idx_ok;
    logic [CW-1:0] cnt_dec;

    logic          cnt_we;
    logic [IW-1:0] cnt_waddr;
    logic [CW-1:0] cnt_wdata;
    logic          stk_we;
    logic [IW-1:0] stk_waddr;
    logic [IW-1:0] stk_wdata;

    logic [31:0] granted_wide;
    logic [31:0] cnt_out_wide;
    logic [31:0] used_wide;

    assign s_idx_wide = 32'(s_slot_index);
    assign idx_wide   = 32'(idx_reg);
    assign s_addr     = s_idx_wide[IW-1:0];
    assign idx_addr   = idx_wide[IW-1:0];
    assign idx_ok     = (idx_reg != '0) && (idx_wide < 32'(SLOTS));
    assign cnt_dec    = cnt_rd_reg - 1'b1;

    assign stat.init_last = (32'(init_reg) == 32'(SLOTS - 1));
    assign stat.out_busy  = m_valid_reg && !m_ready;

    always_comb begin
        status_next   = ST_OK;
        granted_next  = '0;
        cnt_out_next  = '0;
        freed_next    = 1'b0;
        free_top_next = free_top_reg;
        used_next     = used_reg;
        cnt_we        = 1'b0;
        cnt_waddr     = idx_addr;
        cnt_wdata     = '0;
        stk_we        = 1'b0;
        stk_waddr     = free_top_reg;
        stk_wdata     = idx_addr;
        if (cmd.init_wr) begin
            cnt_we    = 1'b1;
            cnt_waddr = init_reg;
            cnt_wdata = '0;
            stk_we    = 1'b1;
            stk_waddr = init_reg;
            stk_wdata = stat.init_last ? '0 : init_reg + 1'b1;
        end else if (cmd.exec) begin
            unique case (req_reg)
                REQ_CLAIM: begin
                    if (free_top_reg == '0) begin
                        status_next = ST_FULL;
                    end else begin
                        granted_next  = stack_rd_reg;
                        cnt_out_next  = CW'(1);
                        free_top_next = free_top_reg - 1'b1;
                        used_next     = used_reg + 1'b1;
                        cnt_we        = 1'b1;
                        cnt_waddr     = stack_rd_reg;
                        cnt_wdata     = CW'(1);
                    end
                end
                REQ_RELEASE, REQ_REF: begin
                    if (!idx_ok) begin
                        status_next = ST_INVALID;
                    end else if (cnt_rd_reg == '0) begin
                        status_next = ST_DEAD;
                    end else if (req_reg == REQ_REF) begin
                        if (cnt_rd_reg == '1) begin
                            status_next  = ST_SAT;
                            cnt_out_next = cnt_rd_reg;
                        end else begin
                            cnt_out_next = cnt_rd_reg + 1'b1;
                            cnt_we       = 1'b1;
                            cnt_wdata    = cnt_rd_reg + 1'b1;
                        end
                    end else begin
                        cnt_out_next = cnt_dec;
                        cnt_we       = 1'b1;
                        cnt_wdata    = cnt_dec;
                        if (cnt_dec == '0) begin
                            freed_next = 1'b1;
                            if (used_reg != '0) begin
                                used_next = used_reg - 1'b1;
                            end
                            if (32'(free_top_reg) < 32'(SLOTS - 1)) begin
                                stk_we        = 1'b1;
                                free_top_next = free_top_reg + 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    status_next = ST_INVALID;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            ref_counts[cnt_waddr] <= cnt_wdata;
        end
        if (cmd.rd) begin
            cnt_rd_reg <= ref_counts[s_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            slot_stack[stk_waddr] <= stk_wdata;
        end
        if (cmd.rd) begin
            stack_rd_reg <= slot_stack[free_top_reg - 1'b1];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            req_reg <= s_req_type;
            idx_reg <= s_slot_index;
        end
        if (cmd.exec) begin
            status_reg  <= status_next;
            granted_reg <= granted_next;
            cnt_out_reg <= cnt_out_next;
            freed_reg   <= freed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg     <= '0;
            free_top_reg <= IW'(SLOTS - 1);
            used_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.init_wr) begin
                init_reg <= init_reg + 1'b1;
            end
            free_top_reg <= free_top_next;
            used_reg     <= used_next;
            if (cmd.exec) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign granted_wide = 32'(granted_reg);
    assign cnt_out_wide = 32'(cnt_out_reg);
    assign used_wide    = 32'(used_reg);

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_granted_index = granted_wide[IDX_W-1:0];
    assign m_count_after   = cnt_out_wide[COUNT_W-1:0];
    assign m_slot_freed    = freed_reg;
    assign m_slots_in_use  = used_wide[USED_W-1:0];

    a_pool_balance: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(used_reg) + 32'(free_top_reg)) == 32'(SLOTS - 1))
        else $error("claimed and free slot totals disagree");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.exec))
        else $error("result appeared without an execute step");

    a_freed_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && freed_reg) |-> (status_reg == ST_OK && cnt_out_reg == '0))
        else $error("freed flag set on a result that did not free its slot");

    a_grant_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && granted_reg != '0) |-> (status_reg == ST_OK))
        else $error("slot granted on a failed request");

endmodule

// ----- sv/refcounted_slot_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_slot_allocator
// Slot allocator with a LIFO free stack and a reference count per slot.
// ----------------------------------------------------------------------------
// After reset the block clears the count memory and loads the free stack,
// with s_ready low. It then takes one request at a time: accepting a request
// reads the free stack and the count memory, and the execute step writes
// both memories back and loads the result register. A request may be
// accepted while the previous result still waits on m_ready; its execute
// step then holds until that result is taken.
// Slot 0 is the null handle and is never granted.
module refcounted_slot_allocator #(
    parameter int SLOTS       = rsa_pkg::SLOTS_DEF,
    parameter int COUNT_WIDTH = rsa_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rsa_pkg::REQ_W-1:0]      s_req_type,
    input  logic [rsa_pkg::IDX_W-1:0]      s_slot_index,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rsa_pkg::STATUS_W-1:0]   m_status,
    output logic [rsa_pkg::IDX_W-1:0]      m_granted_index,
    output logic [rsa_pkg::COUNT_W-1:0]    m_count_after,
    output logic                           m_slot_freed,
    output logic [rsa_pkg::USED_W-1:0]     m_slots_in_use
);
    import rsa_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    rsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rsa_datapath #(
        .SLOTS       (SLOTS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_req_type      (s_req_type),
        .s_slot_index    (s_slot_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_granted_index (m_granted_index),
        .m_count_after   (m_count_after),
        .m_slot_freed    (m_slot_freed),
        .m_slots_in_use  (m_slots_in_use)
    );

endmodule

// ----- test/refcounted_slot_allocator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_slot_allocator_tb
// Self-checking testbench for the reference-counted slot allocator.
// A shadow copy of the free stack and the count memory predicts the result of
// every accepted request. Directed requests cover the null handle, the unused
// request code, dead slots and a pool run dry. Random request mixes follow,
// with random idling on both channels.
// ----------------------------------------------------------------------------
module refcounted_slot_allocator_tb;
    import rsa_pkg::*;

    localparam int    NSLOTS    = SLOTS_DEF;
    localparam int    COUNT_TOP = (1 << COUNT_WIDTH_DEF) - 1;
    localparam int    REPORTED  = 10;
    localparam time   T_HALF    = 10;
    localparam time   T_LIMIT   = 3_000_000;

    typedef struct {
        status_t            status;
        logic [IDX_W-1:0]   granted;
        logic [COUNT_W-1:0] count;
        logic               freed;
        logic [USED_W-1:0]  in_use;
    } alloc_outcome_t;

    class pool_shadow;
        logic [IDX_W-1:0]       slot_stack [NSLOTS];
        logic [COUNT_W-1:0]     ref_counts [NSLOTS];
        int                     free_top;
        int                     used_count;
        alloc_outcome_t         outcomes_due [$];
        int                     fault_count;

        function new();
            for (int i = 0; i < NSLOTS; i++) begin
                slot_stack[i] = (i + 1 < NSLOTS) ? IDX_W'(i + 1) : '0;
                ref_counts[i] = '0;
            end
            free_top    = NSLOTS - 1;
            used_count  = 0;
            fault_count = 0;
        endfunction

        function void apply_request(req_t kind, logic [IDX_W-1:0] idx);
            alloc_outcome_t o;
            o.status  = ST_OK;
            o.granted = '0;
            o.count   = '0;
            o.freed   = 1'b0;
            unique case (kind)
                REQ_CLAIM: begin
                    if (free_top == 0) begin
                        o.status = ST_FULL;
                    end else begin
                        free_top--;
                        o.granted = slot_stack[free_top];
                        ref_counts[o.granted] = COUNT_W'(1);
                        o.count = COUNT_W'(1);
                        used_count++;
                    end
                end
                REQ_RELEASE, REQ_REF: begin
                    if (idx == 0 || int'(idx) >= NSLOTS) begin
                        o.status = ST_INVALID;
                    end else if (ref_counts[idx] == 0) begin
                        o.status = ST_DEAD;
                    end else if (kind == REQ_REF) begin
                        if (ref_counts[idx] == COUNT_W'(COUNT_TOP)) begin
                            o.status = ST_SAT;
                        end else begin
                            ref_counts[idx]++;
                        end
                        o.count = ref_counts[idx];
                    end else begin
                        ref_counts[idx]--;
                        o.count = ref_counts[idx];
                        if (o.count == 0) begin
                            if (used_count > 0) begin
                                used_count--;
                            end
                            if (free_top < NSLOTS - 1) begin
                                slot_stack[free_top] = idx;
                                free_top++;
                            end
                            o.freed = 1'b1;
                        end
                    end
                end
                default: begin
                    o.status = ST_INVALID;
                end
            endcase
            o.in_use = USED_W'(used_count);
            outcomes_due.push_back(o);
        endfunction

        function void note_fault(string field, int want, int got);
            fault_count++;
            if (fault_count <= REPORTED) begin
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            end
        endfunction

        function void check_outcome(logic [STATUS_W-1:0] status,
                                    logic [IDX_W-1:0] granted,
                                    logic [COUNT_W-1:0] count,
                                    logic freed,
                                    logic [USED_W-1:0] in_use);
            alloc_outcome_t o;
            if (outcomes_due.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORTED) begin
                    $display("%0t: result with no request outstanding", $time);
                end
                return;
            end
            o = outcomes_due.pop_front();
            if (status !== o.status) note_fault("status", o.status, status);
            if (granted !== o.granted) note_fault("granted_index", o.granted, granted);
            if (count !== o.count) note_fault("count_after", o.count, count);
            if (freed !== o.freed) note_fault("slot_freed", o.freed, freed);
            if (in_use !== o.in_use) note_fault("slots_in_use", o.in_use, in_use);
        endfunction
    endclass

    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic [REQ_W-1:0]      s_req_type      = '0;
    logic [IDX_W-1:0]      s_slot_index    = '0;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [IDX_W-1:0]      m_granted_index;
    logic [COUNT_W-1:0]    m_count_after;
    logic                  m_slot_freed;
    logic [USED_W-1:0]     m_slots_in_use;

    pool_shadow shadow = new();
    bit         rx_steady = 1'b0;

    refcounted_slot_allocator dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_slot_index    (s_slot_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_granted_index (m_granted_index),
        .m_count_after   (m_count_after),
        .m_slot_freed    (m_slot_freed),
        .m_slots_in_use  (m_slots_in_use)
    );

    always begin
        #T_HALF aclk = 1'b1;
        #T_HALF aclk = 1'b0;
    end

    initial begin
        #T_LIMIT;
        $display("end of test: mismatches");
        $finish;
    end

    // Result side: draws a stall before each item, then takes it.
    initial begin
        int stall;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            @(negedge aclk);
            stall = rx_steady ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            shadow.check_outcome(m_status, m_granted_index, m_count_after,
                                 m_slot_freed, m_slots_in_use);
        end
    end

    task automatic send_request(req_t kind, logic [IDX_W-1:0] idx, int gap);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= kind;
        s_slot_index <= idx;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        shadow.apply_request(kind, idx);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (shadow.outcomes_due.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [IDX_W-1:0] pick_live_slot();
        int live [$];
        for (int i = 1; i < NSLOTS; i++) begin
            if (shadow.ref_counts[i] != 0) live.push_back(i);
        end
        if (live.size() == 0) return '0;
        return IDX_W'(live[$urandom_range(0, live.size() - 1)]);
    endfunction

    task automatic random_request(int claim_pct, bit steady);
        int               roll;
        int               gap;
        req_t             kind;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] live;
        roll = $urandom_range(0, 99);
        gap  = steady ? 0 : $urandom_range(0, 5);
        idx  = IDX_W'($urandom_range(0, 255));
        live = pick_live_slot();
        if (roll < 15) begin
            kind = req_t'($urandom_range(0, 3));
        end else if (roll < 15 + claim_pct * 85 / 100 || live == 0) begin
            kind = REQ_CLAIM;
        end else begin
            idx  = live;
            kind = ($urandom_range(0, 9) < 6) ? REQ_RELEASE : REQ_REF;
        end
        send_request(kind, idx, gap);
    endtask

    initial begin
        int claim_mix [6] = '{25, 65, 25, 65, 40, 40};

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // Null handle, unused code, dead slots, then one claim-reference-release
        // round trip that frees the slot and hands it out again.
        send_request(REQ_RELEASE, 8'd0, 0);
        send_request(REQ_REF, 8'd0, 1);
        send_request(REQ_UNUSED, 8'd255, 0);
        send_request(REQ_UNUSED, 8'h00, 2);
        send_request(REQ_RELEASE, 8'd255, 0);
        send_request(REQ_REF, 8'd128, 0);
        send_request(REQ_CLAIM, 8'hFF, 3);
        send_request(REQ_REF, 8'd255, 0);
        send_request(REQ_RELEASE, 8'd255, 0);
        send_request(REQ_RELEASE, 8'd255, 0);
        send_request(REQ_RELEASE, 8'd255, 1);
        send_request(REQ_CLAIM, 8'h00, 0);
        send_request(REQ_CLAIM, 8'hAA, 0);
        send_request(REQ_REF, 8'd254, 4);
        send_request(REQ_RELEASE, 8'd1, 0);
        send_request(REQ_UNUSED, 8'h55, 5);
        wait_drained();

        // Run the pool dry, then claim on the empty stack.
        while (shadow.free_top > 0) begin
            send_request(REQ_CLAIM, IDX_W'($urandom_range(0, 255)), $urandom_range(0, 5));
        end
        send_request(REQ_CLAIM, 8'd0, 0);
        send_request(REQ_CLAIM, 8'd255, 2);
        wait_drained();

        for (int seg = 0; seg < 6; seg++) begin
            rx_steady = (seg == 3);
            repeat (250) random_request(claim_mix[seg], seg == 3);
            if (seg % 2 == 1) wait_drained();
        end
        rx_steady = 1'b0;

        wait_drained();
        repeat (20) @(posedge aclk);
        if (shadow.fault_count == 0 && shadow.outcomes_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/rsa_pkg.sv
sv/rsa_ctrl.sv
sv/rsa_datapath.sv
sv/refcounted_slot_allocator.sv
test/refcounted_slot_allocator_tb.sv
